@@ src/wbgm_pkg.sv @@
// ============================================================================
// wbgm_pkg: shared types and constants of the bytecode gas meter
// Parse phase codes, the beat passed from front to back, and the opcode cost table.
// ============================================================================
package wbgm_pkg;

    localparam int PhaseW = 5;

    localparam logic [PhaseW-1:0] PH_HDR        = 5'd0;
    localparam logic [PhaseW-1:0] PH_SEC_ID     = 5'd1;
    localparam logic [PhaseW-1:0] PH_SEC_LEN    = 5'd2;
    localparam logic [PhaseW-1:0] PH_SKIP_SEC   = 5'd3;
    localparam logic [PhaseW-1:0] PH_FCOUNT     = 5'd4;
    localparam logic [PhaseW-1:0] PH_BODY_LEN   = 5'd5;
    localparam logic [PhaseW-1:0] PH_LOC_COUNT  = 5'd6;
    localparam logic [PhaseW-1:0] PH_LOC_N      = 5'd7;
    localparam logic [PhaseW-1:0] PH_LOC_TYPE   = 5'd8;
    localparam logic [PhaseW-1:0] PH_OPCODE     = 5'd9;
    localparam logic [PhaseW-1:0] PH_IMM1       = 5'd10;
    localparam logic [PhaseW-1:0] PH_IMM2       = 5'd11;
    localparam logic [PhaseW-1:0] PH_CI_LEB     = 5'd12;
    localparam logic [PhaseW-1:0] PH_CI_TAB     = 5'd13;
    localparam logic [PhaseW-1:0] PH_BRT_COUNT  = 5'd14;
    localparam logic [PhaseW-1:0] PH_BRT_TARGET = 5'd15;
    localparam logic [PhaseW-1:0] PH_SKIP_IMM   = 5'd16;
    localparam logic [PhaseW-1:0] PH_STOPPED    = 5'd17;

    localparam logic [1:0] OUT_PARSED = 2'd0;
    localparam logic [1:0] OUT_SHORT  = 2'd1;
    localparam logic [1:0] OUT_MAGIC  = 2'd2;

    localparam logic [7:0] CODE_SECTION_ID = 8'd10;
    localparam logic [3:0] LEB_MAX_BYTES   = 4'd10;

    // one classified byte from the front
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;     // first byte of an image
        logic [3:0] hdr_idx;   // position 0..7, 8 means past the header
    } beat_t;

    function automatic logic [9:0] opcode_cost(input logic [7:0] op);
        logic [9:0] c;
        c = 10'd1;
        if (op <= 8'h11) begin
            if (op == 8'h10) c = 10'd10;
            else if (op == 8'h11) c = 10'd15;
            else c = 10'd5;
        end else if (op >= 8'h28 && op <= 8'h3E) c = 10'd3;
        else if (op == 8'h3F) c = 10'd2;
        else if (op == 8'h40) c = 10'd1000;
        else if (op >= 8'h45 && op <= 8'h66) c = 10'd2;
        else if (op >= 8'h67 && op <= 8'hA6) begin
            if (op == 8'h6D || op == 8'h6E || op == 8'h6F || op == 8'h7F ||
                op == 8'h80 || op == 8'h81 || op == 8'h95 || op == 8'hA3)
                c = 10'd10;
            else c = 10'd2;
        end else if (op >= 8'hA7 && op <= 8'hC4) c = 10'd3;
        return c;
    endfunction

endpackage

@@ src/wbgm_front.sv @@
// ============================================================================
// wbgm_front: byte intake
// Accepts image bytes and tags each with its header position and first mark.
// ============================================================================
module wbgm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    output logic                q_valid,
    input  logic                q_full,
    output wbgm_pkg::beat_t     q_beat
);

    logic [3:0] pos_reg, pos_next;

    assign stall   = q_full;
    assign q_valid = valid;

    always_comb
    begin
        q_beat.data    = data_byte;
        q_beat.last    = final_byte;
        q_beat.first   = (pos_reg == 4'd0);
        q_beat.hdr_idx = pos_reg;
        pos_next       = pos_reg;
        if (final_byte) pos_next = 4'd0;
        else if (pos_reg != 4'd8) pos_next = pos_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) pos_reg <= 4'd0;
        else if (valid && !q_full) pos_reg <= pos_next;
    end

endmodule

@@ src/wbgm_fifo.sv @@
// ============================================================================
// wbgm_fifo: two-entry queue between intake and parser
// Register-based queue carrying classified beats.
// ============================================================================
module wbgm_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  wbgm_pkg::beat_t wdata,
    output logic            full,
    output logic            not_empty,
    input  logic            rd,
    output wbgm_pkg::beat_t rdata
);

    wbgm_pkg::beat_t mem_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rdata     = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr && !full) wp_reg <= ~wp_reg;
            if (rd && not_empty) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr && !full} - {1'b0, rd && not_empty};
        end
    end

endmodule

@@ src/wbgm_back.sv @@
// ============================================================================
// wbgm_back: section and body parser
// Parses one queued beat per cycle unless stalled, and produces the result.
// ============================================================================
module wbgm_back #(
    parameter int LENGTH_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_rd,
    input  wbgm_pkg::beat_t q_beat,
    output logic            valid,
    input  logic            stall,
    output logic [63:0]     gas_total,
    output logic [1:0]      outcome
);

    localparam logic [LENGTH_BITS-1:0] CountMax = '1;

    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [4:0]  ph_reg, ph_next;
    logic        magic_reg, magic_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  li_reg, li_next;
    logic [63:0] sec_reg, sec_next;
    logic [63:0] fn_reg, fn_next;
    logic [63:0] body_reg, body_next;
    logic [63:0] loc_reg, loc_next;
    logic [63:0] tgt_reg, tgt_next;
    logic [3:0]  skip_reg, skip_next;
    logic [63:0] gas_reg, gas_next;
    logic        code_reg, code_next;
    logic        ov_reg;
    logic [63:0] gas_out_reg;
    logic [1:0]  oc_reg;
    logic        res_ok;

    logic [7:0]  b;
    logic        go_en, fire;
    logic [4:0]  go_ph;
    logic [63:0] acc_fed;
    logic [3:0]  li_fed;
    logic        leb_done;
    logic [63:0] cnt64;
    logic [5:0]  sh;
    logic [4:0]  b_ph;
    logic        b_go;

    // only the last beat of an image waits for the result slot
    assign res_ok = !ov_reg || !stall;
    assign q_rd   = q_valid && (res_ok || !q_beat.last);
    assign fire   = q_rd;
    assign b      = q_beat.data;

    always_comb
    begin
        // state restarts at the first byte of each image
        logic [LENGTH_BITS-1:0] c0;
        logic        m0;
        logic [4:0]  p0;
        logic [63:0] a0;
        logic [3:0]  i0;
        logic [63:0] s0, f0, bd0, l0, t0, g0;
        logic [3:0]  k0;
        logic        cd0;
        c0 = cnt_reg; m0 = magic_reg; p0 = ph_reg; a0 = acc_reg; i0 = li_reg;
        s0 = sec_reg; f0 = fn_reg; bd0 = body_reg; l0 = loc_reg; t0 = tgt_reg;
        g0 = gas_reg; k0 = skip_reg; cd0 = code_reg;
        if (q_beat.first)
        begin
            c0 = '0; m0 = 1'b1; p0 = wbgm_pkg::PH_HDR; a0 = '0; i0 = '0;
            s0 = '0; f0 = '0; bd0 = '0; l0 = '0; t0 = '0; g0 = '0; k0 = '0;
            cd0 = 1'b0;
        end

        cnt_next = (c0 < CountMax) ? c0 + 1'b1 : c0;
        magic_next = m0; acc_next = a0; li_next = i0; sec_next = s0; fn_next = f0;
        body_next = bd0; loc_next = l0; tgt_next = t0; skip_next = k0;
        gas_next = g0; code_next = cd0;
        go_en = 1'b0; go_ph = p0;
        b_go = 1'b0; b_ph = p0;

        sh       = 6'((7 * 32'(i0)) & 63);
        acc_fed  = a0 | (64'(b[6:0]) << sh);
        li_fed   = i0 + 4'd1;
        leb_done = !b[7] || (li_fed >= wbgm_pkg::LEB_MAX_BYTES);

        unique case (p0)
            wbgm_pkg::PH_HDR:
            begin
                if (i0 == 4'd0 && q_beat.hdr_idx < 4'd4)
                begin
                    unique case (q_beat.hdr_idx[1:0])
                        2'd0: if (b != 8'h00) m0 = 1'b0;
                        2'd1: if (b != 8'h61) m0 = 1'b0;
                        2'd2: if (b != 8'h73) m0 = 1'b0;
                        default: if (b != 8'h6D) m0 = 1'b0;
                    endcase
                end
                magic_next = m0;
                if (q_beat.hdr_idx >= 4'd7)
                begin
                    go_en = 1'b1; go_ph = wbgm_pkg::PH_SEC_ID;
                end
            end
            wbgm_pkg::PH_SEC_ID:
            begin
                code_next = (b == wbgm_pkg::CODE_SECTION_ID);
                go_en = 1'b1; go_ph = wbgm_pkg::PH_SEC_LEN;
            end
            wbgm_pkg::PH_SEC_LEN:
            begin
                acc_next = acc_fed; li_next = li_fed;
                if (leb_done)
                begin
                    sec_next = acc_fed; go_en = 1'b1;
                    if (cd0) go_ph = (acc_fed == 0) ? wbgm_pkg::PH_STOPPED
                                                    : wbgm_pkg::PH_FCOUNT;
                    else go_ph = (acc_fed == 0) ? wbgm_pkg::PH_SEC_ID
                                                : wbgm_pkg::PH_SKIP_SEC;
                end
            end
            wbgm_pkg::PH_SKIP_SEC:
            begin
                if (s0 != 0) sec_next = s0 - 1;
                if (sec_next == 0)
                begin
                    go_en = 1'b1; go_ph = wbgm_pkg::PH_SEC_ID;
                end
            end
            wbgm_pkg::PH_FCOUNT:
            begin
                if (s0 != 0) sec_next = s0 - 1;
                acc_next = acc_fed; li_next = li_fed;
                if (leb_done || sec_next == 0)
                begin
                    go_en = 1'b1;
                    if (acc_fed == 0 || sec_next == 0)
                    begin
                        go_ph = (sec_next == 0) ? wbgm_pkg::PH_SEC_ID
                                                : wbgm_pkg::PH_SKIP_SEC;
                        fn_next = acc_fed;
                    end
                    else
                    begin
                        fn_next = acc_fed - 1; go_ph = wbgm_pkg::PH_BODY_LEN;
                    end
                end
            end
            wbgm_pkg::PH_BODY_LEN:
            begin
                if (s0 != 0) sec_next = s0 - 1;
                acc_next = acc_fed; li_next = li_fed;
                if (leb_done || sec_next == 0)
                begin
                    body_next = (acc_fed < sec_next) ? acc_fed : sec_next;
                    go_en = 1'b1; go_ph = wbgm_pkg::PH_LOC_COUNT;
                    if (body_next == 0)
                    begin
                        if (f0 == 0 || sec_next == 0)
                            go_ph = (sec_next == 0) ? wbgm_pkg::PH_SEC_ID
                                                    : wbgm_pkg::PH_SKIP_SEC;
                        else
                        begin
                            fn_next = f0 - 1; go_ph = wbgm_pkg::PH_BODY_LEN;
                        end
                    end
                end
            end
            wbgm_pkg::PH_STOPPED:
            begin
            end
            default:
            begin
                // inside a function body
                if (s0 != 0) sec_next = s0 - 1;
                if (bd0 != 0) body_next = bd0 - 1;
                case (p0)
                    wbgm_pkg::PH_LOC_COUNT:
                    begin
                        acc_next = acc_fed; li_next = li_fed;
                        if (leb_done)
                        begin
                            b_go = 1'b1;
                            if (acc_fed == 0) b_ph = wbgm_pkg::PH_OPCODE;
                            else
                            begin
                                loc_next = acc_fed - 1; b_ph = wbgm_pkg::PH_LOC_N;
                            end
                            if (acc_fed == 0) loc_next = acc_fed;
                        end
                    end
                    wbgm_pkg::PH_LOC_N, wbgm_pkg::PH_IMM1, wbgm_pkg::PH_IMM2,
                    wbgm_pkg::PH_CI_LEB:
                    begin
                        acc_next = acc_fed; li_next = li_fed;
                        if (leb_done)
                        begin
                            b_go = 1'b1;
                            case (p0)
                                wbgm_pkg::PH_LOC_N:  b_ph = wbgm_pkg::PH_LOC_TYPE;
                                wbgm_pkg::PH_IMM1:   b_ph = wbgm_pkg::PH_OPCODE;
                                wbgm_pkg::PH_IMM2:   b_ph = wbgm_pkg::PH_IMM1;
                                default:             b_ph = wbgm_pkg::PH_CI_TAB;
                            endcase
                        end
                    end
                    wbgm_pkg::PH_LOC_TYPE:
                    begin
                        b_go = 1'b1;
                        if (l0 == 0) b_ph = wbgm_pkg::PH_OPCODE;
                        else
                        begin
                            loc_next = l0 - 1; b_ph = wbgm_pkg::PH_LOC_N;
                        end
                    end
                    wbgm_pkg::PH_OPCODE:
                    begin
                        gas_next = g0 + 64'(wbgm_pkg::opcode_cost(b));
                        b_go = 1'b1; b_ph = wbgm_pkg::PH_OPCODE;
                        if (b == 8'h0C || b == 8'h0D || b == 8'h10 ||
                            (b >= 8'h20 && b <= 8'h24) || b == 8'h41 || b == 8'h42)
                            b_ph = wbgm_pkg::PH_IMM1;
                        else if (b == 8'h0E) b_ph = wbgm_pkg::PH_BRT_COUNT;
                        else if (b == 8'h11) b_ph = wbgm_pkg::PH_CI_LEB;
                        else if (b >= 8'h28 && b <= 8'h40) b_ph = wbgm_pkg::PH_IMM2;
                        else if (b == 8'h43)
                        begin
                            skip_next = 4'd4; b_ph = wbgm_pkg::PH_SKIP_IMM;
                        end
                        else if (b == 8'h44)
                        begin
                            skip_next = 4'd8; b_ph = wbgm_pkg::PH_SKIP_IMM;
                        end
                    end
                    wbgm_pkg::PH_CI_TAB:
                    begin
                        b_go = 1'b1; b_ph = wbgm_pkg::PH_OPCODE;
                    end
                    wbgm_pkg::PH_BRT_COUNT:
                    begin
                        acc_next = acc_fed; li_next = li_fed;
                        if (leb_done)
                        begin
                            tgt_next = acc_fed; b_go = 1'b1;
                            b_ph = wbgm_pkg::PH_BRT_TARGET;
                        end
                    end
                    wbgm_pkg::PH_BRT_TARGET:
                    begin
                        acc_next = acc_fed; li_next = li_fed;
                        if (leb_done)
                        begin
                            b_go = 1'b1; b_ph = wbgm_pkg::PH_BRT_TARGET;
                            if (t0 == 0) b_ph = wbgm_pkg::PH_OPCODE;
                            else tgt_next = t0 - 1;
                        end
                    end
                    default:
                    begin
                        if (k0 != 0) skip_next = k0 - 4'd1;
                        if (skip_next == 0)
                        begin
                            b_go = 1'b1; b_ph = wbgm_pkg::PH_OPCODE;
                        end
                    end
                endcase
                go_en = b_go; go_ph = b_ph;
                if (body_next == 0)
                begin
                    go_en = 1'b1;
                    if (fn_next == 0 || sec_next == 0)
                        go_ph = (sec_next == 0) ? wbgm_pkg::PH_SEC_ID
                                                : wbgm_pkg::PH_SKIP_SEC;
                    else
                    begin
                        fn_next = fn_next - 1; go_ph = wbgm_pkg::PH_BODY_LEN;
                    end
                end
            end
        endcase

        ph_next = go_en ? go_ph : p0;
        if (go_en)
        begin
            acc_next = '0; li_next = '0;
        end
        cnt64 = 64'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; ph_reg <= wbgm_pkg::PH_HDR; magic_reg <= 1'b1;
            acc_reg <= '0; li_reg <= '0; sec_reg <= '0; fn_reg <= '0;
            body_reg <= '0; loc_reg <= '0; tgt_reg <= '0; skip_reg <= '0;
            gas_reg <= '0; code_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            if (fire && q_beat.last) ov_reg <= 1'b1;
            else if (!stall) ov_reg <= 1'b0;
            if (fire)
            begin
                cnt_reg <= cnt_next; ph_reg <= ph_next; magic_reg <= magic_next;
                acc_reg <= acc_next; li_reg <= li_next; sec_reg <= sec_next;
                fn_reg <= fn_next; body_reg <= body_next; loc_reg <= loc_next;
                tgt_reg <= tgt_next; skip_reg <= skip_next; gas_reg <= gas_next;
                code_reg <= code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && q_beat.last)
        begin
            if (cnt64 < 64'd8)
            begin
                gas_out_reg <= cnt64 * 64'd10; oc_reg <= wbgm_pkg::OUT_SHORT;
            end
            else if (!magic_next)
            begin
                gas_out_reg <= cnt64 * 64'd10; oc_reg <= wbgm_pkg::OUT_MAGIC;
            end
            else
            begin
                gas_out_reg <= gas_next + cnt64; oc_reg <= wbgm_pkg::OUT_PARSED;
            end
        end
    end

    assign valid     = ov_reg;
    assign gas_total = gas_out_reg;
    assign outcome   = oc_reg;

endmodule

@@ src/wasm_bytecode_gas_meter.sv @@
// ============================================================================
// wasm_bytecode_gas_meter: gas meter for a streamed module image
// Top level: intake, beat queue and parser with registered result.
// ============================================================================
// one byte a cycle while the queue has room: the intake tags each byte, a
// two-entry queue decouples it from the parser, and the parser's state machine
// handles one queued byte per cycle; the result is registered at the edge that
// parses the last byte and is held in an output register; only the last byte of
// the next image waits for it, so the rest of that image can stream in
// meanwhile
module wasm_bytecode_gas_meter #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] gas_total,
    output logic [1:0]  outcome
);

    wbgm_pkg::beat_t wbeat, rbeat;
    logic            wr, full, not_empty, rd;

    wbgm_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .data_byte(data_byte), .final_byte(final_byte),
        .q_valid(wr), .q_full(full), .q_beat(wbeat)
    );

    wbgm_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr(wr), .wdata(wbeat), .full(full),
        .not_empty(not_empty), .rd(rd), .rdata(rbeat)
    );

    wbgm_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(not_empty), .q_rd(rd), .q_beat(rbeat),
        .valid(out_valid), .stall(out_stall), .gas_total(gas_total),
        .outcome(outcome)
    );

`ifndef NO_ASSERTIONS
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome == wbgm_pkg::OUT_PARSED ||
                       outcome == wbgm_pkg::OUT_SHORT ||
                       outcome == wbgm_pkg::OUT_MAGIC))
        else $error("outcome code out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gas_total))
        else $error("stalled result changed");
    a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> !in_stall)
        else $error("input stalled with queue space");
`endif

endmodule
